@@ rtl/itrc_pkg.sv @@
// ----------------------------------------------------------------------------
// itrc_pkg
// Shared types, sizes and character codes for the integer-to-text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itrc_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int GROUP_SIZE  = 3;
  localparam int STEP_BITS   = 8;

  // worst case: every bit a digit, a comma per full group, one sign
  localparam int STORE_DEPTH = VALUE_WIDTH + (VALUE_WIDTH - 1) / GROUP_SIZE + 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int DIV_STEPS   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int QUOT_W      = DIV_STEPS * STEP_BITS;
  localparam int STEP_CW     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int GRP_W       = $clog2(GROUP_SIZE);
  localparam int BASE_W      = 6;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;

  typedef logic [7:0] char_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_COMMA,
    S_SIGN,
    S_FETCH
  } state_t;

  // digit value 0..35 to its ASCII glyph
  function automatic char_t digit_glyph(input logic [BASE_W-1:0] d, input logic lower);
    char_t base_ch;
    base_ch = lower ? CH_LOWER_A : CH_UPPER_A;
    if (d < BASE_DEC) begin
      digit_glyph = CH_ZERO + 8'(d);
    end else begin
      digit_glyph = base_ch + 8'(d) - 8'(BASE_DEC);
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/integer_to_text_radix_converter_top.sv @@
// ----------------------------------------------------------------------------
// integer_to_text_radix_converter_top
// Converts one value per request to ASCII text in radix 2..36 or signed
// decimal, with optional digit grouping, up to two characters per result.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in_      | in_valid / in_ready  | number_bits, signed_mode, digit_base,
//           |                      | lower_letters, group_commas, show_plus
//  out_     | out_valid / out_ready| char_first, char_second, char_count,
//           |                      | last_chunk
//
//  a request is accepted in S_IDLE, then runs long division per digit (S_DIV),
//  a comma per group (S_COMMA), the sign (S_SIGN) and one fetch per result (S_FETCH).
//  the long division takes STEP_BITS quotient bits a cycle, which sets the rate.
//  in_ready is high only between conversions; the last result may still wait.
//  out_ready low holds the result registers and pauses the text read-out.
//  rst_n is synchronous; the text store is not cleared, it is written before read.
`default_nettype none

module integer_to_text_radix_converter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_number_bits,
  input  wire logic        in_signed_mode,
  input  wire logic [5:0]  in_digit_base,
  input  wire logic        in_lower_letters,
  input  wire logic        in_group_commas,
  input  wire logic        in_show_plus,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char_first,
  output logic [7:0]       out_char_second,
  output logic [1:0]       out_char_count,
  output logic             out_last_chunk
);

  localparam int VW = itrc_pkg::VALUE_WIDTH;
  localparam int QW = itrc_pkg::QUOT_W;
  localparam int SB = itrc_pkg::STEP_BITS;
  localparam int BW = itrc_pkg::BASE_W;
  localparam int IW = itrc_pkg::IDX_W;
  localparam int AW = itrc_pkg::ADDR_W;
  localparam int CW = itrc_pkg::STEP_CW;
  localparam int GW = itrc_pkg::GRP_W;

  itrc_pkg::state_t state_r, state_nxt;

  // control
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   step_r, step_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [GW-1:0]   grp_r, grp_nxt;

  // per-request payload
  logic [QW-1:0]   quot_r, quot_nxt;
  logic [BW-1:0]   rem_r, rem_nxt;
  logic [BW-1:0]   base_r, base_nxt;
  logic            lower_r, lower_nxt;
  logic            commas_r, commas_nxt;
  logic            has_sign_r, has_sign_nxt;
  itrc_pkg::char_t sign_ch_r, sign_ch_nxt;
  logic            out_pair_r, out_pair_nxt;
  logic            out_last_r, out_last_nxt;
  itrc_pkg::char_t out_first_r, out_second_r;

  // text store
  itrc_pkg::char_t store_mem [itrc_pkg::STORE_DEPTH];
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  itrc_pkg::char_t wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;

  // datapath terms
  logic [SB-1:0]   chunk;
  logic [SB-1:0]   qbits;
  logic [BW:0]     trial;
  logic [BW-1:0]   rem_step;
  logic [QW-1:0]   quot_step;
  logic            digit_done;
  logic            quot_zero;
  logic            comma_due;
  logic            in_fire;
  logic            fetch_fire;
  logic [IW-1:0]   idx_dec;
  logic [IW-1:0]   pos_b;
  logic [IW-1:0]   chars_left;
  logic            left_pair;
  logic            left_last;
  logic [VW-1:0]   in_value;
  logic            in_neg;
  logic [VW-1:0]   in_mag;
  logic [BW-1:0]   in_base;

  assign in_ready   = (state_r == itrc_pkg::S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign fetch_fire = (state_r == itrc_pkg::S_FETCH) && (!out_valid_r || out_ready);

  assign out_valid       = out_valid_r;
  assign out_char_first  = out_first_r;
  assign out_char_second = out_pair_r ? out_second_r : 8'h00;
  assign out_char_count  = out_pair_r ? 2'd2 : 2'd1;
  assign out_last_chunk  = out_last_r;

  // request decode: sign, magnitude and effective radix
  always_comb begin
    in_value = in_number_bits[VW-1:0];
    in_neg   = in_signed_mode && in_value[VW-1];
    in_mag   = in_neg ? (~in_value + 1'b1) : in_value;
    if (in_signed_mode) begin
      in_base = itrc_pkg::BASE_DEC;
    end else if (in_digit_base < itrc_pkg::BASE_MIN) begin
      in_base = itrc_pkg::BASE_MIN;
    end else if (in_digit_base > itrc_pkg::BASE_MAX) begin
      in_base = itrc_pkg::BASE_MAX;
    end else begin
      in_base = in_digit_base;
    end
  end

  // one slice of long division: STEP_BITS restoring steps on a narrow remainder
  always_comb begin
    chunk = quot_r[QW-1 -: SB];
    qbits = '0;
    trial = '0;
    rem_step = rem_r;
    for (int i = 0; i < SB; i++) begin
      trial = {rem_step, chunk[SB-1-i]};
      if (trial >= {1'b0, base_r}) begin
        trial = trial - {1'b0, base_r};
        qbits[SB-1-i] = 1'b1;
      end
      rem_step = trial[BW-1:0];
    end
    quot_step  = (quot_r << SB) | QW'(qbits);
    digit_done = (state_r == itrc_pkg::S_DIV) && (step_r == CW'(itrc_pkg::DIV_STEPS - 1));
    quot_zero  = (quot_step == '0);
    comma_due  = commas_r && !quot_zero && (grp_r == GW'(itrc_pkg::GROUP_SIZE - 1));
  end

  // read-out position
  always_comb begin
    idx_dec    = idx_r - 1'b1;
    pos_b      = pos_r + 1'b1;
    chars_left = IW'(itrc_pkg::STORE_DEPTH) - pos_r;
    left_pair  = (chars_left >= IW'(2));
    left_last  = (chars_left <= IW'(2));
    rd_addr_a  = pos_r[AW-1:0];
    rd_addr_b  = (pos_b < IW'(itrc_pkg::STORE_DEPTH)) ? pos_b[AW-1:0] : pos_r[AW-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itrc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = itrc_pkg::S_DIV;
      end
      itrc_pkg::S_DIV: begin
        if (digit_done) begin
          if (quot_zero) state_nxt = itrc_pkg::S_SIGN;
          else if (comma_due) state_nxt = itrc_pkg::S_COMMA;
        end
      end
      itrc_pkg::S_COMMA: state_nxt = itrc_pkg::S_DIV;
      itrc_pkg::S_SIGN:  state_nxt = itrc_pkg::S_FETCH;
      itrc_pkg::S_FETCH: begin
        if (fetch_fire && left_last) state_nxt = itrc_pkg::S_IDLE;
      end
      default: state_nxt = itrc_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    quot_nxt     = quot_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    grp_nxt      = grp_r;
    base_nxt     = base_r;
    lower_nxt    = lower_r;
    commas_nxt   = commas_r;
    has_sign_nxt = has_sign_r;
    sign_ch_nxt  = sign_ch_r;
    out_pair_nxt = out_pair_r;
    out_last_nxt = out_last_r;
    wr_en        = 1'b0;
    wr_addr      = idx_dec[AW-1:0];
    wr_data      = itrc_pkg::CH_COMMA;
    rd_en        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      itrc_pkg::S_IDLE: begin
        if (in_valid) begin
          quot_nxt     = QW'(in_mag);
          rem_nxt      = '0;
          step_nxt     = '0;
          grp_nxt      = '0;
          idx_nxt      = IW'(itrc_pkg::STORE_DEPTH);
          base_nxt     = in_base;
          lower_nxt    = in_lower_letters && !in_signed_mode;
          commas_nxt   = in_group_commas;
          has_sign_nxt = in_neg || (in_signed_mode && in_show_plus);
          sign_ch_nxt  = in_neg ? itrc_pkg::CH_MINUS : itrc_pkg::CH_PLUS;
        end
      end
      itrc_pkg::S_DIV: begin
        quot_nxt = quot_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + 1'b1;
        if (digit_done) begin
          step_nxt = '0;
          rem_nxt  = '0;
          wr_en    = 1'b1;
          wr_data  = itrc_pkg::digit_glyph(rem_step, lower_r);
          idx_nxt  = idx_dec;
          grp_nxt  = (grp_r == GW'(itrc_pkg::GROUP_SIZE - 1)) ? '0 : grp_r + 1'b1;
        end
      end
      itrc_pkg::S_COMMA: begin
        wr_en   = 1'b1;
        idx_nxt = idx_dec;
      end
      itrc_pkg::S_SIGN: begin
        wr_en   = has_sign_r;
        wr_data = sign_ch_r;
        idx_nxt = has_sign_r ? idx_dec : idx_r;
        pos_nxt = has_sign_r ? idx_dec : idx_r;
      end
      itrc_pkg::S_FETCH: begin
        if (fetch_fire) begin
          rd_en         = 1'b1;
          out_valid_nxt = 1'b1;
          out_pair_nxt  = left_pair;
          out_last_nxt  = left_last;
          pos_nxt       = left_pair ? pos_r + IW'(2) : pos_b;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itrc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      grp_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      grp_r       <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    base_r     <= base_nxt;
    lower_r    <= lower_nxt;
    commas_r   <= commas_nxt;
    has_sign_r <= has_sign_nxt;
    sign_ch_r  <= sign_ch_nxt;
    out_pair_r <= out_pair_nxt;
    out_last_r <= out_last_nxt;
  end

  // text store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      out_first_r  <= store_mem[rd_addr_a];
      out_second_r <= store_mem[rd_addr_b];
    end
  end

  // a new request always starts at the first slice of the first digit
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == itrc_pkg::S_DIV) && (step_r == '0))
    else $error("request did not start a fresh division");

  // the store is sized so text never runs off its low end
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itrc_pkg::S_DIV || state_r == itrc_pkg::S_COMMA) |-> (idx_r != '0))
    else $error("text store overflow");

  // a fetch always presents a result on the next cycle
  a_fetch_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_fire |=> out_valid_r)
    else $error("fetched result not presented");

  // fetching the last result ends the conversion
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fetch_fire && left_last) |=> (state_r == itrc_pkg::S_IDLE) && out_last_r)
    else $error("last result did not end conversion");

endmodule

`default_nettype wire

@@ bench/integer_to_text_radix_converter_top_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_text_radix_converter_top_tb
// Sends conversion requests (directed corner cases, then random ones) and
// checks every text chunk against fixed text or a local model of the
// converter, under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_text_radix_converter_top_tb;

  localparam int          RANDOM_REQUESTS = 145;
  localparam int          IDLE_PCT        = 32;
  localparam int          HOLD_CYCLES     = 1500;
  localparam int          HOLD_AFTER      = 40;
  localparam int          STALL_LIMIT     = 20000;
  localparam int          DRAIN_CYCLES    = 200;
  localparam logic [63:0] VALUE_MASK      = {64{1'b1}} >> (64 - itrc_pkg::VALUE_WIDTH);
  localparam logic [63:0] ALL_ONES        = {64{1'b1}};
  localparam logic [63:0] TOP_BIT         = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0]                 number_bits;
    logic                        signed_mode;
    logic [itrc_pkg::BASE_W-1:0] digit_base;
    logic                        lower_letters;
    logic                        group_commas;
    logic                        show_plus;
  } req_t;

  typedef struct packed {
    itrc_pkg::char_t first;
    itrc_pkg::char_t second;
    logic [1:0]      count;
    logic            last;
  } chunk_t;

  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_ready;
  logic [63:0]                 in_number_bits   = '0;
  logic                        in_signed_mode   = 1'b0;
  logic [itrc_pkg::BASE_W-1:0] in_digit_base    = '0;
  logic                        in_lower_letters = 1'b0;
  logic                        in_group_commas  = 1'b0;
  logic                        in_show_plus     = 1'b0;
  logic                        out_valid;
  logic                        out_ready        = 1'b0;
  logic [7:0]                  out_char_first;
  logic [7:0]                  out_char_second;
  logic [1:0]                  out_char_count;
  logic                        out_last_chunk;

  chunk_t pending_text[$];
  req_t   directed_reqs[$];
  string  directed_text[$];
  chunk_t want_chunk;
  logic   calm           = 1'b0;
  int     fail_count     = 0;
  int     requests_sent  = 0;
  int     chunks_checked = 0;
  int     hold_left      = 0;
  bit     hold_done      = 1'b0;
  int     quiet_cycles   = 0;

  integer_to_text_radix_converter_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number_bits   (in_number_bits),
    .in_signed_mode   (in_signed_mode),
    .in_digit_base    (in_digit_base),
    .in_lower_letters (in_lower_letters),
    .in_group_commas  (in_group_commas),
    .in_show_plus     (in_show_plus),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_first   (out_char_first),
    .out_char_second  (out_char_second),
    .out_char_count   (out_char_count),
    .out_last_chunk   (out_last_chunk)
  );

  always #4 clk = ~clk;

  // split text into chunks of up to two characters, last one marked
  function automatic void pack_text(input itrc_pkg::char_t txt[$]);
    chunk_t c;
    int     pos;
    pos = 0;
    while (pos < txt.size()) begin
      c.first = txt[pos];
      if (txt.size() - pos >= 2) begin
        c.second = txt[pos + 1];
        c.count  = 2'd2;
        pos      = pos + 2;
      end else begin
        c.second = 8'h00;
        c.count  = 2'd1;
        pos      = pos + 1;
      end
      c.last = (pos >= txt.size());
      pending_text.push_back(c);
    end
  endfunction

  function automatic void pack_literal(input string s);
    itrc_pkg::char_t txt[$];
    int              i;
    for (i = 0; i < s.len(); i++) txt.push_back(itrc_pkg::char_t'(s[i]));
    pack_text(txt);
  endfunction

  function automatic void render_number(input req_t r);
    itrc_pkg::char_t txt[$];
    logic [63:0]     mag;
    logic [63:0]     radix;
    logic [63:0]     d;
    logic            lower;
    itrc_pkg::char_t sign_ch;
    itrc_pkg::char_t alpha;
    int              ndig;
    mag     = r.number_bits & VALUE_MASK;
    radix   = 64'(r.digit_base);
    lower   = r.lower_letters;
    sign_ch = 8'h00;
    if (radix < 64'(itrc_pkg::BASE_MIN)) radix = 64'(itrc_pkg::BASE_MIN);
    if (radix > 64'(itrc_pkg::BASE_MAX)) radix = 64'(itrc_pkg::BASE_MAX);
    if (r.signed_mode) begin
      radix = 64'(itrc_pkg::BASE_DEC);
      lower = 1'b0;
      if (mag[itrc_pkg::VALUE_WIDTH-1]) begin
        sign_ch = itrc_pkg::CH_MINUS;
        mag     = (~mag + 64'd1) & VALUE_MASK;
      end else if (r.show_plus) begin
        sign_ch = itrc_pkg::CH_PLUS;
      end
    end
    alpha = lower ? itrc_pkg::CH_LOWER_A : itrc_pkg::CH_UPPER_A;
    if (mag == 0) begin
      txt.push_front(itrc_pkg::CH_ZERO);
    end else begin
      ndig = 0;
      while (mag != 0) begin
        // comma goes ahead of every full group, counted from the right
        if (r.group_commas && ndig != 0 && ndig % itrc_pkg::GROUP_SIZE == 0) begin
          txt.push_front(itrc_pkg::CH_COMMA);
        end
        d = mag % radix;
        if (d < 64'(itrc_pkg::BASE_DEC)) begin
          txt.push_front(itrc_pkg::CH_ZERO + 8'(d));
        end else begin
          txt.push_front(alpha + 8'(d) - 8'(itrc_pkg::BASE_DEC));
        end
        mag  = mag / radix;
        ndig = ndig + 1;
      end
    end
    if (sign_ch != 8'h00) txt.push_front(sign_ch);
    pack_text(txt);
  endfunction

  function automatic void add_row(input logic [63:0] v, input bit sm, input int b, input bit lo,
                                  input bit gc, input bit sp, input string want);
    req_t r;
    r.number_bits   = v;
    r.signed_mode   = sm;
    r.digit_base    = itrc_pkg::BASE_W'(b);
    r.lower_letters = lo;
    r.group_commas  = gc;
    r.show_plus     = sp;
    directed_reqs.push_back(r);
    directed_text.push_back(want);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   kind;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      r.number_bits = {$urandom, $urandom};
    end else if (kind <= 6) begin
      r.number_bits = {$urandom, $urandom} >> $urandom_range(1, 63);
    end else if (kind == 7) begin
      case ($urandom_range(0, 4))
        0:       r.number_bits = '0;
        1:       r.number_bits = ALL_ONES;
        2:       r.number_bits = TOP_BIT;
        3:       r.number_bits = ~TOP_BIT;
        default: r.number_bits = 64'd1;
      endcase
    end else begin
      r.number_bits = 64'($urandom_range(0, 2000));
    end
    r.signed_mode   = ($urandom_range(0, 4) < 2);
    // mostly legal radixes, sometimes anything the field can hold
    r.digit_base    = ($urandom_range(0, 9) == 0) ? itrc_pkg::BASE_W'($urandom_range(0, 63))
                                                  : itrc_pkg::BASE_W'($urandom_range(2, 36));
    r.lower_letters = 1'($urandom_range(0, 1));
    r.group_commas  = 1'($urandom_range(0, 1));
    r.show_plus     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic offer_request(input req_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_number_bits   <= r.number_bits;
    in_signed_mode   <= r.signed_mode;
    in_digit_base    <= r.digit_base;
    in_lower_letters <= r.lower_letters;
    in_group_commas  <= r.group_commas;
    in_show_plus     <= r.show_plus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // result side: check, then pick next ready, with one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected text chunk %h %h count %0d last %0d",
               out_char_first, out_char_second, out_char_count, out_last_chunk);
        fail_count++;
      end else begin
        want_chunk = pending_text.pop_front();
        if (out_char_first !== want_chunk.first) begin
          $error("char_first: expected %h, got %h", want_chunk.first, out_char_first);
          fail_count++;
        end
        if (out_char_second !== want_chunk.second) begin
          $error("char_second: expected %h, got %h", want_chunk.second, out_char_second);
          fail_count++;
        end
        if (out_char_count !== want_chunk.count) begin
          $error("char_count: expected %0d, got %0d", want_chunk.count, out_char_count);
          fail_count++;
        end
        if (out_last_chunk !== want_chunk.last) begin
          $error("last_chunk: expected %0d, got %0d", want_chunk.last, out_last_chunk);
          fail_count++;
        end
      end
      chunks_checked++;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && chunks_checked >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or chunk moved in %0d cycles", STALL_LIMIT);
      $display("integer_to_text_radix_converter_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // value, signed, radix, lower, commas, plus, text ("" = from the model)
    add_row(64'd0,    0, 10, 0, 0, 0, "0");
    add_row(64'd0,    1, 10, 0, 0, 1, "+0");
    add_row(ALL_ONES, 0, 10, 0, 0, 0, "18446744073709551615");
    add_row(ALL_ONES, 0, 10, 0, 1, 0, "18,446,744,073,709,551,615");
    add_row(ALL_ONES, 1, 10, 0, 0, 1, "-1");
    add_row(TOP_BIT,  1, 10, 0, 0, 0, "-9223372036854775808");
    add_row(TOP_BIT,  1, 10, 0, 1, 0, "-9,223,372,036,854,775,808");
    add_row(~TOP_BIT, 1, 10, 0, 0, 1, "+9223372036854775807");
    add_row(ALL_ONES, 0, 2,  0, 0, 0, "");
    add_row(ALL_ONES, 0, 2,  0, 1, 0, "");
    add_row(ALL_ONES, 0, 16, 0, 0, 0, "FFFFFFFFFFFFFFFF");
    add_row(ALL_ONES, 0, 16, 1, 0, 0, "ffffffffffffffff");
    add_row(ALL_ONES, 0, 36, 1, 1, 0, "");
    add_row(64'd35,   0, 36, 0, 0, 0, "Z");
    add_row(64'd35,   0, 36, 1, 0, 0, "z");
    add_row(64'd5,    0, 0,  0, 0, 0, "101");
    add_row(64'd2,    0, 1,  0, 0, 0, "10");
    add_row(64'd35,   0, 63, 0, 0, 0, "Z");
    add_row(64'd255,  1, 16, 1, 0, 0, "255");
    add_row(64'd42,   0, 10, 0, 0, 1, "42");
    add_row(64'd123,  0, 10, 0, 0, 0, "123");
    add_row(64'hFF,   0, 2,  0, 1, 0, "11,111,111");
    add_row(64'd1000, 0, 10, 0, 1, 0, "1,000");
    add_row(64'd999,  0, 10, 0, 1, 0, "999");
    add_row(64'd100,  1, 10, 0, 1, 1, "+100");

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < directed_reqs.size(); i++) begin
      offer_request(directed_reqs[i]);
      if (directed_text[i].len() != 0) pack_literal(directed_text[i]);
      else render_number(directed_reqs[i]);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      req_t r;
      // a stretch where neither side idles
      if (i == 60) calm <= 1'b1;
      if (i == 100) calm <= 1'b0;
      r = random_request();
      offer_request(r);
      render_number(r);
    end
    in_valid <= 1'b0;

    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d requests (%0d directed corners, %0d random), %0d text chunks checked",
             requests_sent, directed_reqs.size(), RANDOM_REQUESTS, chunks_checked);
    $display("covered radix clamping, signed and unsigned text, commas, sign options, long stall");
    if (fail_count == 0) begin
      $display("integer_to_text_radix_converter_top_tb OK");
    end else begin
      $display("integer_to_text_radix_converter_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ integer_to_text_radix_converter_top.f @@
rtl/itrc_pkg.sv
rtl/integer_to_text_radix_converter_top.sv
bench/integer_to_text_radix_converter_top_tb.sv
